// ===== hdl/ptd_pkg.sv =====
// package for the periodic task tick dispatcher
// beat types, action codes, scan states and the cell control group; no dependencies
`default_nettype none
package ptd_pkg;

  localparam int SLOTS_DEF       = 8;
  localparam int PERIOD_BITS_DEF = 16;
  localparam int SLOT_W          = 4;
  localparam int IN_PERIOD_W     = 16;

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_ADD      = 2'd1,
    ACT_DISPATCH = 2'd2,
    ACT_NONE     = 2'd3
  } ptd_action_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } ptd_state_t;

  typedef struct packed {
    ptd_action_t            action;
    logic [SLOT_W-1:0]      priority_req;
    logic [IN_PERIOD_W-1:0] period;
  } ptd_in_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] task_slot;
    logic              irq_enabled;
  } ptd_out_t;

  typedef struct packed {
    logic tick;
    logic scan;
  } ptd_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/ptd_cell.sv =====
// one task slot: period, countdown, armed and ready flags, and the scan token stage
// depends on ptd_pkg
`default_nettype none
module ptd_cell #(
  parameter int PERIOD_BITS = ptd_pkg::PERIOD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ptd_pkg::ptd_ctl_t      ctl,
  input  logic                   load,
  input  logic [PERIOD_BITS-1:0] load_period,
  input  logic                   start,
  input  logic                   tok_in,
  output logic                   tok_out,
  output logic                   hit
);
  import ptd_pkg::*;

  logic [PERIOD_BITS-1:0] period_r, period_nxt;
  logic [PERIOD_BITS-1:0] count_r, count_nxt;
  logic                   armed_r, armed_nxt;
  logic                   ready_r, ready_nxt;
  logic                   tok_r, tok_nxt;

  assign hit     = ctl.scan & tok_r & ready_r;
  assign tok_out = ctl.scan & tok_r & ~ready_r;

  always_comb begin
    period_nxt = period_r;
    count_nxt  = count_r;
    armed_nxt  = armed_r;
    ready_nxt  = ready_r;
    if (load) begin
      period_nxt = load_period;
      count_nxt  = load_period;
      armed_nxt  = 1'b1;
      ready_nxt  = 1'b0;
    end else if (ctl.tick && armed_r) begin
      if (count_r == '0) begin
        ready_nxt = 1'b1;
        if (period_r == '0) begin
          armed_nxt = 1'b0;
        end else begin
          count_nxt = period_r - PERIOD_BITS'(1);
        end
      end else begin
        count_nxt = count_r - PERIOD_BITS'(1);
      end
    end
    if (hit) begin
      ready_nxt = 1'b0;
    end
    tok_nxt = ctl.scan ? tok_in : start;
  end

  always_ff @(posedge clk) begin
    period_r <= period_nxt;
    count_r  <= count_nxt;
    if (!rst_n) begin
      armed_r <= 1'b0;
      ready_r <= 1'b0;
      tok_r   <= 1'b0;
    end else begin
      armed_r <= armed_nxt;
      ready_r <= ready_nxt;
      tok_r   <= tok_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/periodic_task_tick_dispatcher.sv =====
// tick, add and none beats: registered result, one beat per cycle unless out_stall
// dispatch beats: a token walks the ring of slot cells one cell per cycle,
// result registered on a hit or after a full lap; next beat is taken once it is out
// reset clears slot flags, the scan pointer to slot 1 and sets the interrupt enable
// top level of the periodic task tick dispatcher; depends on ptd_pkg and ptd_cell
`default_nettype none
module periodic_task_tick_dispatcher #(
  parameter int SLOTS       = ptd_pkg::SLOTS_DEF,
  parameter int PERIOD_BITS = ptd_pkg::PERIOD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ptd_pkg::ptd_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output ptd_pkg::ptd_out_t out_data
);
  import ptd_pkg::*;

  localparam int IDX = $clog2(SLOTS);

  ptd_state_t             state_r, state_nxt;
  logic [IDX-1:0]         ptr_r, ptr_nxt;
  logic [IDX-1:0]         cur_r, cur_nxt;
  logic [IDX-1:0]         cnt_r, cnt_nxt;
  logic                   irq_r, irq_nxt;
  logic                   out_valid_r, out_valid_nxt;
  ptd_out_t               out_data_r, out_data_nxt;

  ptd_ctl_t               ctl;
  logic                   tick_en;
  logic [SLOTS-1:0]       load_vec;
  logic [SLOTS-1:0]       start_vec;
  logic [SLOTS-1:0]       tok_out_vec;
  logic [SLOTS-1:0]       hit_vec;
  logic [PERIOD_BITS-1:0] load_period;
  logic                   accept;
  logic                   add_ok;
  logic [IDX-1:0]         add_idx;
  logic [IDX:0]           cur_plus;
  logic                   cur_last;

  assign load_period = PERIOD_BITS'(in_data.period);
  assign add_ok      = (in_data.priority_req != '0) &&
                       (32'(in_data.priority_req) <= 32'(SLOTS));
  assign add_idx     = IDX'(in_data.priority_req - SLOT_W'(1));
  assign cur_plus    = {1'b0, cur_r} + (IDX+1)'(1);
  assign cur_last    = (cur_r == IDX'(SLOTS - 1));

  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign ctl = '{tick: tick_en, scan: (state_r == ST_SCAN)};

  genvar gi;
  generate
    for (gi = 0; gi < SLOTS; gi++) begin : g_cell
      localparam int PREV = (gi == 0) ? SLOTS - 1 : gi - 1;
      ptd_cell #(
        .PERIOD_BITS(PERIOD_BITS)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .load       (load_vec[gi]),
        .load_period(load_period),
        .start      (start_vec[gi]),
        .tok_in     (tok_out_vec[PREV]),
        .tok_out    (tok_out_vec[gi]),
        .hit        (hit_vec[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    irq_nxt       = irq_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    tick_en       = 1'b0;
    load_vec      = '0;
    start_vec     = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.action)
            ACT_TICK: begin
              tick_en       = 1'b1;
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{found: 1'b0, task_slot: '0, irq_enabled: irq_r};
            end
            ACT_ADD: begin
              if (add_ok) begin
                load_vec[add_idx] = 1'b1;
              end
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{found: 1'b0, task_slot: '0, irq_enabled: irq_r};
            end
            ACT_DISPATCH: begin
              start_vec[ptr_r] = 1'b1;
              cur_nxt          = ptr_r;
              cnt_nxt          = '0;
              state_nxt        = ST_SCAN;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{found: 1'b0, task_slot: '0, irq_enabled: irq_r};
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (|hit_vec) begin
          irq_nxt       = 1'b0;
          ptr_nxt       = cur_last ? '0 : IDX'(cur_plus);
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{found: 1'b1, task_slot: SLOT_W'(cur_plus), irq_enabled: 1'b0};
          state_nxt     = ST_IDLE;
        end else if (cnt_r == IDX'(SLOTS - 1)) begin
          irq_nxt       = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{found: 1'b0, task_slot: '0, irq_enabled: 1'b1};
          state_nxt     = ST_IDLE;
        end else begin
          cur_nxt = cur_last ? '0 : IDX'(cur_plus);
          cnt_nxt = cnt_r + IDX'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ptr_r       <= '0;
      irq_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      irq_r       <= irq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// self-checking bench for the periodic task tick dispatcher: directed and random beats,
// each result beat compared with an in-bench scheduler prediction
// depends on ptd_pkg and periodic_task_tick_dispatcher
`timescale 1ns / 100ps
module tb_top;
  import ptd_pkg::*;

  localparam int SLOTS        = SLOTS_DEF;
  localparam int PBITS        = PERIOD_BITS_DEF;
  localparam int RANDOM_ITEMS = 500;
  localparam int DRAIN_CYCLES = 3 * SLOTS + 10;
  localparam int CYCLE_LIMIT  = 400000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  ptd_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ptd_out_t out_data;

  // predicted scheduler state
  logic [PBITS-1:0] slot_period_m [SLOTS];
  logic [PBITS-1:0] slot_count_m [SLOTS];
  logic             slot_armed_m [SLOTS];
  logic             slot_ready_m [SLOTS];
  int               scan_ptr_m;
  logic             irq_m;

  ptd_in_t  pending_items [$];
  ptd_out_t due_results [$];
  int       mismatch_count = 0;
  int       cycle_count = 0;
  int       send_gap = 0;
  int       send_calm = 0;
  int       stall_left = 0;
  int       stall_calm = 0;

  periodic_task_tick_dispatcher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic ptd_out_t sched_step(ptd_in_t item);
    ptd_out_t res;
    int s;
    int n;
    int p;
    bit hit;
    res = '0;
    hit = 1'b0;
    case (item.action)
      ACT_TICK: begin
        for (s = 0; s < SLOTS; s++) begin
          if (slot_armed_m[s]) begin
            if (slot_count_m[s] == '0) begin
              slot_ready_m[s] = 1'b1;
              if (slot_period_m[s] == '0) slot_armed_m[s] = 1'b0;
              else slot_count_m[s] = slot_period_m[s] - 1'b1;
            end else begin
              slot_count_m[s] = slot_count_m[s] - 1'b1;
            end
          end
        end
      end
      ACT_ADD: begin
        if (item.priority_req >= 1 && item.priority_req <= SLOTS) begin
          s = item.priority_req - 1;
          slot_period_m[s] = item.period;
          slot_count_m[s]  = item.period;
          slot_armed_m[s]  = 1'b1;
          slot_ready_m[s]  = 1'b0;
        end
      end
      ACT_DISPATCH: begin
        p = scan_ptr_m;
        for (n = 0; n < SLOTS && !hit; n++) begin
          if (slot_ready_m[p]) begin
            slot_ready_m[p] = 1'b0;
            irq_m = 1'b0;
            scan_ptr_m = (p + 1 >= SLOTS) ? 0 : p + 1;
            res.found = 1'b1;
            res.task_slot = SLOT_W'(p + 1);
            hit = 1'b1;
          end else if (p + 1 < SLOTS) begin
            p++;
          end else begin
            irq_m = 1'b1;
            p = 0;
          end
        end
        if (!hit) scan_ptr_m = p;
      end
      default: ;
    endcase
    res.irq_enabled = irq_m;
    return res;
  endfunction

  function automatic ptd_in_t make_item(ptd_action_t act, int slot, int per);
    ptd_in_t it;
    it.action       = act;
    it.priority_req = SLOT_W'(slot);
    it.period       = IN_PERIOD_W'(per);
    return it;
  endfunction

  function automatic ptd_in_t random_item();
    ptd_in_t it;
    int r;
    it = make_item(ACT_TICK, $urandom_range(0, 15), $urandom_range(0, 65535));
    r = $urandom_range(0, 99);
    if (r < 38) begin
      it.action = ACT_TICK;
    end else if (r < 62) begin
      it.action = ACT_ADD;
      if ($urandom_range(0, 9) != 0) it.priority_req = SLOT_W'($urandom_range(1, SLOTS));
      r = $urandom_range(0, 99);
      if (r < 40) it.period = IN_PERIOD_W'($urandom_range(0, 3));
      else if (r < 80) it.period = IN_PERIOD_W'($urandom_range(4, 24));
      else if (r < 88) it.period = '1;
    end else if (r < 96) begin
      it.action = ACT_DISPATCH;
    end else begin
      it.action = ACT_NONE;
    end
    return it;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || due_results.size() > 0) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) due_results.push_back(sched_step(in_data));
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
        if (send_calm > 0) begin
          send_calm <= send_calm - 1;
          send_gap  <= 0;
        end else begin
          send_gap <= idle_len();
          if ($urandom_range(0, 99) < 3) send_calm <= $urandom_range(20, 60);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    ptd_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, got found=%0d slot=%0d irq=%0d",
                   $time, out_data.found, out_data.task_slot, out_data.irq_enabled);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = due_results.pop_front();
          if (out_data.found !== want.found || out_data.task_slot !== want.task_slot ||
              out_data.irq_enabled !== want.irq_enabled) begin
            $display("%0t: mismatch, expected found=%0d slot=%0d irq=%0d, got found=%0d slot=%0d irq=%0d",
                     $time, want.found, want.task_slot, want.irq_enabled,
                     out_data.found, out_data.task_slot, out_data.irq_enabled);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (stall_calm > 0) begin
          stall_calm <= stall_calm - 1;
        end else begin
          stall_left <= idle_len();
          if ($urandom_range(0, 99) < 3) stall_calm <= $urandom_range(20, 60);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    ptd_in_t item;
    int effective;
    bit paused;
    for (int s = 0; s < SLOTS; s++) begin
      slot_period_m[s] = '0;
      slot_count_m[s]  = '0;
      slot_armed_m[s]  = 1'b0;
      slot_ready_m[s]  = 1'b0;
    end
    scan_ptr_m = 0;
    irq_m = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // empty lap, ignored items, one-shot, last slot wrap, reload over ready
    pending_items.push_back(make_item(ACT_DISPATCH, 0, 0));
    pending_items.push_back(make_item(ACT_TICK, 0, 0));
    pending_items.push_back(make_item(ACT_ADD, 0, 5));
    pending_items.push_back(make_item(ACT_ADD, 9, 5));
    pending_items.push_back(make_item(ACT_ADD, 15, 65535));
    pending_items.push_back(make_item(ACT_NONE, 15, 65535));
    pending_items.push_back(make_item(ACT_ADD, 1, 0));
    pending_items.push_back(make_item(ACT_TICK, 0, 0));
    pending_items.push_back(make_item(ACT_TICK, 15, 65535));
    pending_items.push_back(make_item(ACT_ADD, 8, 1));
    pending_items.push_back(make_item(ACT_TICK, 0, 0));
    pending_items.push_back(make_item(ACT_TICK, 0, 0));
    pending_items.push_back(make_item(ACT_DISPATCH, 0, 0));
    pending_items.push_back(make_item(ACT_DISPATCH, 15, 65535));
    pending_items.push_back(make_item(ACT_DISPATCH, 0, 0));
    pending_items.push_back(make_item(ACT_ADD, 2, 65535));
    pending_items.push_back(make_item(ACT_ADD, 3, 2));
    pending_items.push_back(make_item(ACT_TICK, 0, 0));
    pending_items.push_back(make_item(ACT_TICK, 0, 0));
    pending_items.push_back(make_item(ACT_TICK, 0, 0));
    pending_items.push_back(make_item(ACT_DISPATCH, 0, 0));
    pending_items.push_back(make_item(ACT_ADD, 8, 0));
    pending_items.push_back(make_item(ACT_DISPATCH, 0, 0));
    pending_items.push_back(make_item(ACT_ADD, 4, 16'h8000));
    pending_items.push_back(make_item(ACT_DISPATCH, 0, 0));
    wait_idle();

    effective = 0;
    paused = 1'b0;
    while (effective < RANDOM_ITEMS) begin
      item = random_item();
      if (item.action != ACT_NONE &&
          !(item.action == ACT_ADD && (item.priority_req == 0 || item.priority_req > SLOTS)))
        effective++;
      pending_items.push_back(item);
      if (effective == RANDOM_ITEMS / 2 && !paused) begin
        wait_idle();
        paused = 1'b1;
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
